@@ rtl/stbs_pkg.sv @@
// Package for the sorted table binary search block.
// Holds table sizing constants and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int CFG_W       = 11;
  localparam int IDX_W       = 10;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 10;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic wr;
    logic load;
    logic step;
    logic capture;
    logic hit;
  } stbs_cmd_t;

  typedef struct packed {
    logic more;
    logic hit;
  } stbs_status_t;

endpackage

`default_nettype wire

@@ rtl/stbs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/stbs_dp.sv @@
// Datapath for the sorted table binary search: table RAM, search bounds,
// probe address, key register, count register and result register.
// Depends on stbs_pkg and stbs_ram.
`default_nettype none

module stbs_dp
  import stbs_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_W-1:0]          cfg_wdata,
  input  wire logic [IDX_W-1:0]          entry_index,
  input  wire logic signed [VAL_W-1:0]   entry_value,
  input  wire logic signed [VAL_W-1:0]   search_key,
  input  wire stbs_cmd_t                 cmd,
  output stbs_status_t                   status,
  output logic                           found,
  output logic [POS_W-1:0]               position
);

  logic [CFG_W-1:0]        entries_in_use;
  logic [CNT_W-1:0]        n_sat;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hi;
  logic [CNT_W-1:0]        lo_next;
  logic [CNT_W-1:0]        hi_next;
  logic [CNT_W:0]          mid_sum;
  logic [ADDR_W-1:0]       mid;
  logic [ADDR_W-1:0]       mid_next;
  logic signed [VAL_W-1:0] key;
  logic [VAL_W-1:0]        rdata;
  logic                    less;
  logic                    in_range;

  // The upper bound is kept one past the last candidate, so the live range is lo .. hi-1.
  always_comb begin
    if (32'(entries_in_use) > 32'(TABLE_DEPTH)) begin
      n_sat = CNT_W'(TABLE_DEPTH);
    end else begin
      n_sat = CNT_W'(entries_in_use);
    end
    less = $signed(rdata) < key;
    if (cmd.load) begin
      lo_next = '0;
      hi_next = n_sat;
    end else if (less) begin
      lo_next = CNT_W'(mid) + CNT_W'(1);
      hi_next = hi;
    end else begin
      lo_next = lo;
      hi_next = CNT_W'(mid);
    end
    mid_sum     = {1'b0, lo_next} + {1'b0, hi_next} - (CNT_W + 1)'(1);
    mid_next    = mid_sum[ADDR_W:1];
    status.more = lo_next < hi_next;
    status.hit  = $signed(rdata) == key;
    in_range    = 32'(entry_index) < 32'(TABLE_DEPTH);
  end

  stbs_ram #(
    .WIDTH(VAL_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr && in_range),
    .waddr (ADDR_W'(entry_index)),
    .wdata (entry_value),
    .re    (cmd.load || cmd.step),
    .raddr (mid_next),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= search_key;
    end
    if (cmd.load || cmd.step) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
    end
    if (cmd.capture) begin
      found    <= cmd.hit;
      position <= cmd.hit ? POS_W'(mid) : '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/stbs_ctrl.sv @@
// Controller for the sorted table binary search: sequences writes, probes
// and result delivery, and owns the output valid flag.
// Depends on stbs_pkg.
`default_nettype none

module stbs_ctrl
  import stbs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic         action,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire stbs_status_t status,
  output stbs_cmd_t         cmd
);

  typedef enum logic [1:0] {
    IDLE,
    PROBE,
    EMPTY
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  always_comb begin
    s_tready = state == IDLE;
    accept   = s_tvalid && s_tready;
    out_free = !m_tvalid || m_tready;
    cmd      = '0;
    case (state)
      IDLE: begin
        cmd.wr   = accept && action == ACT_WRITE;
        cmd.load = accept && action == ACT_SEARCH;
      end
      PROBE: begin
        if (status.hit || !status.more) begin
          cmd.capture = out_free;
          cmd.hit     = status.hit;
        end else begin
          cmd.step = 1'b1;
        end
      end
      EMPTY: begin
        cmd.capture = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= status.more ? PROBE : EMPTY;
          end
        end
        PROBE, EMPTY: begin
          if (cmd.capture) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/sorted_table_binary_search.sv @@
// Sorted table binary search, top level. A search item is loaded and then
// probes the table until it hits or the range is empty (the registered RAM read
// feeds the compare and next-midpoint logic). The result register lets the next
// item be accepted while a result waits. Reset clears the entry count and the
// output valid; the table contents are undefined until written.
// Depends on stbs_pkg, stbs_ctrl and stbs_dp.
`default_nettype none

module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0: entry_index[9:0], entry_value[41:10], search_key[73:42], zero pad.
  input  wire logic [79:0]      s_tdata,
  // Field: action.
  input  wire logic             s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // Fields from bit 0: position[9:0], zero pad.
  output logic [15:0]           m_tdata,
  // Field: found.
  output logic                  m_tuser
);

  stbs_cmd_t        cmd;
  stbs_status_t     status;
  logic [POS_W-1:0] position;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stbs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .entry_index (s_tdata[9:0]),
    .entry_value (s_tdata[41:10]),
    .search_key  (s_tdata[73:42]),
    .cmd         (cmd),
    .status      (status),
    .found       (m_tuser),
    .position    (position)
  );

  assign m_tdata = {6'b0, position};

endmodule

`default_nettype wire

@@ bench/lookup_checker.sv @@
// Checker for the sorted table binary search block: watches the item, result and
// register channels, predicts each search result from its own table copy and compares.
// Depends on stbs_pkg.
module lookup_checker
  import stbs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  // Fields from bit 0: entry_index[9:0], entry_value[41:10], search_key[73:42], zero pad.
  input  wire logic [79:0]      s_tdata,
  // Field: action.
  input  wire logic             s_tuser,
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  // Fields from bit 0: position[9:0], zero pad.
  input  wire logic [15:0]      m_tdata,
  // Field: found.
  input  wire logic             m_tuser,
  output int                    failures,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } lookup_result_t;

  logic signed [VAL_W-1:0] table_words [TABLE_DEPTH];
  logic [CFG_W-1:0]        span_count;
  lookup_result_t          expected_q [$];

  function automatic lookup_result_t predict_lookup(input logic signed [VAL_W-1:0] key);
    int             lo;
    int             hi;
    int             mid;
    lookup_result_t res;
    res = '0;
    lo  = 0;
    hi  = (span_count > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(span_count) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (table_words[mid] == key) begin
        res.found    = 1'b1;
        res.position = POS_W'(mid);
        return res;
      end
      if (table_words[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    if (rst) begin
      span_count = '0;
      expected_q.delete();
      failures <= 0;
    end else begin
      if (cfg_we) begin
        span_count = cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == ACT_WRITE) begin
          table_words[s_tdata[IDX_W-1:0]] = s_tdata[IDX_W +: VAL_W];
        end else begin
          expected_q.push_back(predict_lookup(s_tdata[IDX_W+VAL_W +: VAL_W]));
        end
      end
      if (m_tvalid && m_tready) begin
        got.found    = m_tuser;
        got.position = m_tdata[POS_W-1:0];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result found=%0b position=%0d", $time,
                   got.found, got.position);
          failures <= failures + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.found !== got.found || want.position !== got.position) begin
            $display("%0t: expected found=%0b position=%0d, actual found=%0b position=%0d",
                     $time, want.found, want.position, got.found, got.position);
            failures <= failures + 1;
          end
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

@@ bench/sorted_table_binary_search_test.sv @@
// Top of the testbench for the sorted table binary search block: drives table
// writes, searches and entry count settings, and gives the verdict.
// Depends on stbs_pkg, sorted_table_binary_search and lookup_checker.
module sorted_table_binary_search_test
  import stbs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VAL_MIN        = 32'sh8000_0000;
  localparam int VAL_MAX        = 32'sh7fff_ffff;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_TARGET    = 1370;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [79:0]      s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [15:0]      m_tdata;
  logic             m_tuser;

  int failures;
  int outstanding;
  int items_sent = 0;
  int burst_left = 0;
  int span_now = 0;
  int shadow [TABLE_DEPTH];
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_span = 0;
  int stall_tick = 0;

  sorted_table_binary_search dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  lookup_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(20, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (stall_tick % 5 != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_item(input logic action, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic [VAL_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {6'b0, key, val, idx};
    do @(posedge clk); while (!s_tready);
    items_sent = items_sent + 1;
  endtask

  task automatic write_entry(input int idx, input int val);
    shadow[idx] = val;
    send_item(ACT_WRITE, IDX_W'(idx), val, $urandom);
  endtask

  task automatic lookup(input int key);
    send_item(ACT_SEARCH, IDX_W'($urandom), $urandom, key);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input int n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(n);
    @(posedge clk);
    cfg_we   <= 1'b0;
    span_now = n;
  endtask

  task automatic fill_table(input int n, input bit shuffled);
    int vals [$];
    int spread;
    spread = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 4) == 0) begin
        vals.push_back(vals[i-1]);
      end else if (spread == 0) begin
        vals.push_back(int'($urandom_range(0, 4 * n)) - 2 * n);
      end else begin
        vals.push_back(int'($urandom));
      end
    end
    if (shuffled) begin
      vals.shuffle();
    end else begin
      vals.sort();
    end
    for (int i = 0; i < n; i++) begin
      write_entry(i, vals[i]);
    end
  endtask

  function automatic int pick_key();
    int depth;
    int sel;
    depth = (span_now > TABLE_DEPTH) ? TABLE_DEPTH : span_now;
    sel   = $urandom_range(0, 9);
    if (depth == 0 || sel >= 8) begin
      return $urandom;
    end
    if (sel < 6) begin
      return shadow[$urandom_range(0, depth - 1)];
    end
    return shadow[$urandom_range(0, depth - 1)] + ($urandom_range(0, 1) ? 1 : -1);
  endfunction

  initial begin
    int sel;
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // An empty table never matches.
    set_count(0);
    lookup(0);
    lookup(VAL_MIN);
    lookup(VAL_MAX);

    write_entry(0, VAL_MIN);
    write_entry(1, -1);
    write_entry(2, 0);
    write_entry(3, VAL_MAX);
    write_entry(TABLE_DEPTH - 1, VAL_MAX);
    set_count(4);
    lookup(VAL_MIN);
    lookup(-1);
    lookup(0);
    lookup(VAL_MAX);
    lookup(-2);
    lookup(1);
    lookup(VAL_MAX - 1);

    set_count(1);
    lookup(VAL_MIN);
    lookup(5);

    // On an unsorted table the probe path can miss a key that is present.
    write_entry(0, 5);
    write_entry(1, 1);
    write_entry(2, 9);
    write_entry(3, 3);
    set_count(4);
    lookup(1);
    lookup(3);

    fill_table(TABLE_DEPTH, 1'b0);
    set_count(TABLE_DEPTH);
    repeat (100) lookup(pick_key());
    set_count(2047);
    repeat (40) lookup(pick_key());
    set_count(TABLE_DEPTH + 1);
    repeat (30) lookup(pick_key());
    set_count(TABLE_DEPTH - 1);
    repeat (30) lookup(pick_key());

    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        n = $urandom_range(1, 16);
      end else if (sel < 8) begin
        n = $urandom_range(17, 64);
      end else begin
        n = $urandom_range(1, 2);
      end
      fill_table(n, $urandom_range(0, 5) == 0);
      set_count(n);
      repeat ($urandom_range(5, 15)) lookup(pick_key());
      if ($urandom_range(0, 4) == 0) begin
        set_count($urandom_range(0, 1) ? 2047 : TABLE_DEPTH);
        repeat (5) lookup(pick_key());
      end
    end

    drain();
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/stbs_dp.sv
rtl/stbs_ctrl.sv
rtl/sorted_table_binary_search.sv
bench/lookup_checker.sv
bench/sorted_table_binary_search_test.sv
